// ----- src/bilinear_texture_sampler_core_defines.svh -----
// Assertion macros shared by the checker of the texture sampler core.
// No dependencies; include by bare file name.
`ifndef BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define BTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bts: property violated");

// Clocked assertion that also holds across reset.
`define BTS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bts: property violated across reset");

`endif

// ----- src/bts_pkg.sv -----
// Types and fixed constants of the bilinear texture sampler.
// Used by every module of the sampler; depends on nothing.
package bts_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int NUM_CHAN    = 3;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 16;
  localparam int OUT_TDATA_W = NUM_CHAN * COLOR_W;
  localparam int TEXEL_W     = NUM_CHAN * CHAN_W;
  localparam int ADDR_IN_W   = 16;
  localparam int COORD_W     = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CFG_WIDTH_RESET  = 11'd256;
  localparam logic [CFG_DATA_W-1:0] CFG_HEIGHT_RESET = 11'd256;

  localparam logic MODE_WRITE = 1'b0;

  typedef struct packed {
    logic valid;
    logic is_write;
  } stage_ctl_t;

endpackage

// ----- src/bilinear_texture_sampler_core.sv -----
// Top level of the bilinear texture sampler: ports, size registers, pipeline enable.
// Depends on bts_pkg, bts_addr_gen, bts_texel_store and bts_blend.
//
// Bilinear texture sampler. A word with in_tuser low writes one RGB texel at a linear
// address; a word with in_tuser high samples at signed Q7.16 coordinates u and v and
// returns one word of Q8.8 red, green and blue. The block takes one word per clock while
// the pipeline is not held; a texel write returns nothing. The pipeline is three
// coordinate/address stages, one store read stage and two blend stages. The four corner
// texels come from two replicated copies of the texel store, each read at two addresses a
// cycle (top row from one copy, bottom row from the other); every write lands in both
// copies at the same stage as the reads, so a sample that follows a write in the very next
// word already sees the new texel. The whole pipeline holds only while a finished result
// waits in the output register and the consumer does not take it. The store has no reset
// and no clearing pass: an entry reads back undefined until it is written. STORE_DEPTH
// must be a power of two; addresses wrap modulo the depth. The user must write the size
// registers only while no sample is in flight; the block itself does not enforce it.
module bilinear_texture_sampler_core import bts_pkg::*; #(
  parameter int STORE_DEPTH = 65536,
  parameter int MAX_SIDE = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata, lowest bit up: texel_address[15:0], texel_red[23:16], texel_green[31:24],
  // texel_blue[39:32], u_coord[63:40], v_coord[87:64]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: mode (0 write texel, 1 sample)
  input  logic                   in_tuser,
  // out_tdata, lowest bit up: red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int FRAC_W = COORD_FRAC_BITS;

  // Zero means one texel; anything above the largest side saturates.
  function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_DATA_W-1:0] reg_v);
    if (reg_v == '0) side_of = SIDE_W'(1);
    else if (int'(reg_v) > MAX_SIDE) side_of = SIDE_W'(MAX_SIDE);
    else side_of = SIDE_W'(reg_v);
  endfunction

  logic [CFG_DATA_W-1:0]           width_r, height_r;
  logic [SIDE_W-1:0]               side_w, side_h;
  logic [IDX_W-1:0]                wm1, hm1;
  logic                            adv, in_acc;
  stage_ctl_t                      ctl;
  logic [ADDR_W-1:0]               wr_addr, rd_tl, rd_tr, rd_bl, rd_br;
  logic [TEXEL_W-1:0]              wr_texel, tl_texel, tr_texel, bl_texel, br_texel;
  logic [FRAC_W-1:0]               frac_s, frac_t;
  logic                            out_valid;
  logic [NUM_CHAN-1:0][COLOR_W-1:0] color;
  logic [TEXEL_W-1:0]              in_texel;

  // Size registers; always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_RESET;
      height_r <= CFG_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEXTURE_WIDTH:  width_r  <= cfg_data;
        CFG_TEXTURE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign side_w = side_of(width_r);
  assign side_h = side_of(height_r);
  assign wm1    = IDX_W'(side_w - SIDE_W'(1));
  assign hm1    = IDX_W'(side_h - SIDE_W'(1));

  // Advance every stage unless a result waits in the output register untaken.
  assign adv       = !out_valid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // Texel word packs red high, blue low.
  assign in_texel = {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]};

  bts_addr_gen #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_SIDE(MAX_SIDE),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_addr_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_acc   (in_acc),
    .in_mode  (in_tuser),
    .in_addr  (in_tdata[15:0]),
    .in_texel (in_texel),
    .in_u     (in_tdata[63:40]),
    .in_v     (in_tdata[87:64]),
    .wm1      (wm1),
    .hm1      (hm1),
    .side_w   (side_w),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_texel (wr_texel),
    .rd_tl    (rd_tl),
    .rd_tr    (rd_tr),
    .rd_bl    (rd_bl),
    .rd_br    (rd_br),
    .frac_s   (frac_s),
    .frac_t   (frac_t)
  );

  bts_texel_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk      (clk),
    .adv      (adv),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_texel (wr_texel),
    .rd_tl    (rd_tl),
    .rd_tr    (rd_tr),
    .rd_bl    (rd_bl),
    .rd_br    (rd_br),
    .tl_texel (tl_texel),
    .tr_texel (tr_texel),
    .bl_texel (bl_texel),
    .br_texel (br_texel)
  );

  bts_blend #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (ctl),
    .frac_s    (frac_s),
    .frac_t    (frac_t),
    .tl_texel  (tl_texel),
    .tr_texel  (tr_texel),
    .bl_texel  (bl_texel),
    .br_texel  (br_texel),
    .out_valid (out_valid),
    .color     (color)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = color;

endmodule

// ----- src/bts_addr_gen.sv -----
// Coordinate front end: clamp, scale, split into index and fraction, form texel addresses.
// Depends on bts_pkg.
module bts_addr_gen import bts_pkg::*; #(
  parameter int STORE_DEPTH = 65536,
  parameter int MAX_SIDE = 1024,
  parameter int COORD_FRAC_BITS = 16,
  localparam int ADDR_W = $clog2(STORE_DEPTH),
  localparam int IDX_W = $clog2(MAX_SIDE),
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int FRAC_W = COORD_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_acc,
  input  logic                     in_mode,
  input  logic [ADDR_IN_W-1:0]     in_addr,
  input  logic [TEXEL_W-1:0]       in_texel,
  input  logic [COORD_W-1:0]       in_u,
  input  logic [COORD_W-1:0]       in_v,
  input  logic [IDX_W-1:0]         wm1,
  input  logic [IDX_W-1:0]         hm1,
  input  logic [SIDE_W-1:0]        side_w,
  output stage_ctl_t               ctl,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [TEXEL_W-1:0]       wr_texel,
  output logic [ADDR_W-1:0]        rd_tl,
  output logic [ADDR_W-1:0]        rd_tr,
  output logic [ADDR_W-1:0]        rd_bl,
  output logic [ADDR_W-1:0]        rd_br,
  output logic [FRAC_W-1:0]        frac_s,
  output logic [FRAC_W-1:0]        frac_t
);

  localparam int CW    = FRAC_W + 1;
  localparam int CMP_W = (FRAC_W + 2 > COORD_W) ? FRAC_W + 2 : COORD_W;
  localparam int PW    = CW + IDX_W;
  localparam int BW    = IDX_W + SIDE_W;
  localparam int LW    = (BW + 1 > ADDR_W) ? BW + 1 : ADDR_W;
  localparam int WA_W  = (ADDR_IN_W > ADDR_W) ? ADDR_IN_W : ADDR_W;
  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_W;

  // Negative to zero, above one to one.
  function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
    logic [CMP_W-1:0] mag;
    mag = CMP_W'(raw[COORD_W-2:0]);
    if (raw[COORD_W-1]) clamp_coord = '0;
    else if (mag > ONE_CMP) clamp_coord = CW'(ONE_CMP);
    else clamp_coord = mag[CW-1:0];
  endfunction

  stage_ctl_t           s1_ctl_r, s2_ctl_r, s3_ctl_r, s1_ctl_nxt;
  logic [CW-1:0]        s1_u_r, s1_v_r;
  logic [ADDR_W-1:0]    s1_addr_r, s2_addr_r, s3_addr_r;
  logic [TEXEL_W-1:0]   s1_texel_r, s2_texel_r, s3_texel_r;
  logic [PW-1:0]        s2_px_r, s2_py_r;
  logic [IDX_W-1:0]     s3_left_r, s3_right_r;
  logic [BW-1:0]        s3_base_r;
  logic [FRAC_W-1:0]    s3_s_r, s3_t_r;
  logic [WA_W-1:0]      wa_ext;
  logic [IDX_W-1:0]     left_nxt, top_nxt;
  logic [FRAC_W-1:0]    s_nxt, t_nxt;
  logic [LW-1:0]        base_top, base_bot, lin_tl, lin_tr, lin_bl, lin_br;

  assign wa_ext = WA_W'(in_addr);
  assign s1_ctl_nxt = '{valid: in_acc, is_write: (in_mode == MODE_WRITE)};

  assign left_nxt = s2_px_r[FRAC_W +: IDX_W];
  assign top_nxt  = s2_py_r[FRAC_W +: IDX_W];
  assign s_nxt    = s2_px_r[FRAC_W-1:0];
  assign t_nxt    = s2_py_r[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u_r     <= clamp_coord(in_u);
      s1_v_r     <= clamp_coord(in_v);
      s1_addr_r  <= wa_ext[ADDR_W-1:0];
      s1_texel_r <= in_texel;
      s2_px_r    <= PW'(s1_u_r) * PW'(wm1);
      s2_py_r    <= PW'(s1_v_r) * PW'(hm1);
      s2_addr_r  <= s1_addr_r;
      s2_texel_r <= s1_texel_r;
      s3_left_r  <= left_nxt;
      s3_right_r <= left_nxt + IDX_W'(s_nxt != '0);
      s3_base_r  <= BW'(top_nxt) * BW'(side_w);
      s3_s_r     <= s_nxt;
      s3_t_r     <= t_nxt;
      s3_addr_r  <= s2_addr_r;
      s3_texel_r <= s2_texel_r;
    end
  end

  // Bottom row starts one row further down only when the vertical fraction is nonzero.
  assign base_top = LW'(s3_base_r);
  assign base_bot = base_top + ((s3_t_r != '0) ? LW'(side_w) : LW'(0));
  assign lin_tl = base_top + LW'(s3_left_r);
  assign lin_tr = base_top + LW'(s3_right_r);
  assign lin_bl = base_bot + LW'(s3_left_r);
  assign lin_br = base_bot + LW'(s3_right_r);

  assign ctl      = s3_ctl_r;
  assign wr_addr  = s3_addr_r;
  assign wr_texel = s3_texel_r;
  assign rd_tl    = lin_tl[ADDR_W-1:0];
  assign rd_tr    = lin_tr[ADDR_W-1:0];
  assign rd_bl    = lin_bl[ADDR_W-1:0];
  assign rd_br    = lin_br[ADDR_W-1:0];
  assign frac_s   = s3_s_r;
  assign frac_t   = s3_t_r;

endmodule

// ----- src/bts_texel_store.sv -----
// Texel store: two replicated copies, each with one write and two registered reads.
// Depends on bts_pkg.
module bts_texel_store import bts_pkg::*; #(
  parameter int STORE_DEPTH = 65536,
  localparam int ADDR_W = $clog2(STORE_DEPTH)
) (
  input  logic               clk,
  input  logic               adv,
  input  stage_ctl_t         ctl,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [TEXEL_W-1:0] wr_texel,
  input  logic [ADDR_W-1:0]  rd_tl,
  input  logic [ADDR_W-1:0]  rd_tr,
  input  logic [ADDR_W-1:0]  rd_bl,
  input  logic [ADDR_W-1:0]  rd_br,
  output logic [TEXEL_W-1:0] tl_texel,
  output logic [TEXEL_W-1:0] tr_texel,
  output logic [TEXEL_W-1:0] bl_texel,
  output logic [TEXEL_W-1:0] br_texel
);

  logic [TEXEL_W-1:0] mem_top [STORE_DEPTH];
  logic [TEXEL_W-1:0] mem_bot [STORE_DEPTH];
  logic [TEXEL_W-1:0] tl_r, tr_r, bl_r, br_r;

  // Write both copies; top copy serves the upper row, bottom copy the lower row.
  always_ff @(posedge clk) begin
    if (adv && ctl.valid && ctl.is_write) begin
      mem_top[wr_addr] <= wr_texel;
      mem_bot[wr_addr] <= wr_texel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl_r <= mem_top[rd_tl];
      tr_r <= mem_top[rd_tr];
      bl_r <= mem_bot[rd_bl];
      br_r <= mem_bot[rd_br];
    end
  end

  assign tl_texel = tl_r;
  assign tr_texel = tr_r;
  assign bl_texel = bl_r;
  assign br_texel = br_r;

endmodule

// ----- src/bts_blend.sv -----
// Bilinear blend: horizontal lerp per row, then vertical lerp, per colour lane.
// Depends on bts_pkg.
module bts_blend import bts_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16,
  localparam int FRAC_W = COORD_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  stage_ctl_t                        ctl,
  input  logic [FRAC_W-1:0]                 frac_s,
  input  logic [FRAC_W-1:0]                 frac_t,
  input  logic [TEXEL_W-1:0]                tl_texel,
  input  logic [TEXEL_W-1:0]                tr_texel,
  input  logic [TEXEL_W-1:0]                bl_texel,
  input  logic [TEXEL_W-1:0]                br_texel,
  output logic                              out_valid,
  output logic [NUM_CHAN-1:0][COLOR_W-1:0]  color
);

  localparam int HW = FRAC_W + CHAN_W + 1;
  localparam int SW = 2 * FRAC_W + CHAN_W + 2;
  localparam int SHIFT = 2 * FRAC_W - CHAN_W;
  localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};

  logic                            s4_smp_r, s5_smp_r, out_valid_r;
  logic [FRAC_W-1:0]               s4_s_r, s4_t_r, s5_t_r;
  logic [FRAC_W:0]                 ns, nt;
  logic [NUM_CHAN-1:0][HW-1:0]     top_nxt, bot_nxt, s5_top_r, s5_bot_r;
  logic [NUM_CHAN-1:0][SW-1:0]     sum;
  logic [NUM_CHAN-1:0][COLOR_W-1:0] color_r;

  assign ns = ONE - {1'b0, s4_s_r};
  assign nt = ONE - {1'b0, s5_t_r};

  // Lane 0 is red, held in the top byte of a texel.
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      top_nxt[k] = HW'(tl_texel[TEXEL_W-CHAN_W*(k+1) +: CHAN_W]) * HW'(ns)
                 + HW'(tr_texel[TEXEL_W-CHAN_W*(k+1) +: CHAN_W]) * HW'(s4_s_r);
      bot_nxt[k] = HW'(bl_texel[TEXEL_W-CHAN_W*(k+1) +: CHAN_W]) * HW'(ns)
                 + HW'(br_texel[TEXEL_W-CHAN_W*(k+1) +: CHAN_W]) * HW'(s4_s_r);
      sum[k] = SW'(s5_top_r[k]) * SW'(nt) + SW'(s5_bot_r[k]) * SW'(s5_t_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_smp_r    <= 1'b0;
      s5_smp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s4_smp_r    <= ctl.valid && !ctl.is_write;
      s5_smp_r    <= s4_smp_r;
      out_valid_r <= s5_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s_r   <= frac_s;
      s4_t_r   <= frac_t;
      s5_t_r   <= s4_t_r;
      s5_top_r <= top_nxt;
      s5_bot_r <= bot_nxt;
      for (int k = 0; k < NUM_CHAN; k++) begin
        color_r[k] <= sum[k][SHIFT +: COLOR_W];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign color     = color_r;

endmodule

// ----- src/bts_checker.sv -----
// Port-level checker for the texture sampler core, bound to the top level.
// Depends on bts_pkg and bilinear_texture_sampler_core_defines.svh.
`include "bilinear_texture_sampler_core_defines.svh"

module bts_checker import bts_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A result word waiting untaken holds.
  `BTS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // Input side stalls only behind a held result.
  `BTS_ASSERT(a_in_ready, clk, rst_n, (!out_tvalid || out_tready) |-> in_tready)

  // A blend of bytes never exceeds 255.0 in Q8.8.
  `BTS_ASSERT(a_color_range, clk, rst_n, out_tvalid |-> (out_tdata[15:0] <= 16'hFF00) && (out_tdata[31:16] <= 16'hFF00) && (out_tdata[47:32] <= 16'hFF00))

  // Reset drops any pending result.
  `BTS_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid)

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (.*);
